@@ rtl/grid_bilinear_field_kick_macros.svh @@
`ifndef GRID_BILINEAR_FIELD_KICK_MACROS_SVH
`define GRID_BILINEAR_FIELD_KICK_MACROS_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define GBK_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define GBK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/gbk_pkg.sv @@
package gbk_pkg;

	localparam int GRID_COLS = 64;
	localparam int GRID_ROWS = 64;
	localparam int COL_W = $clog2(GRID_COLS);
	localparam int ROW_W = $clog2(GRID_ROWS);
	localparam int IDX_W = 12;
	localparam int VAL_W = 32;
	localparam int FRAC_W = 16;
	localparam int CNT_W = 7;
	localparam int SIZE_W = 31;
	localparam int REL_W = VAL_W + 1;
	localparam int QUO_W = COL_W + FRAC_W;
	localparam int DIV_W = SIZE_W + COL_W;
	localparam int DIV_LAT = 1 + QUO_W / 2;
	localparam int INT_LAT = 5;
	localparam int BANK_AW = (COL_W - 1) + (ROW_W - 1);
	localparam int BANK_DEPTH = 1 << BANK_AW;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W = 32;
	localparam int S_TDATA_W = 144;
	localparam int M_TDATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_DX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_DY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_KICK = 3'd6;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Item payload while the cell index is being found.
	typedef struct packed {
		logic cmd;
		logic [IDX_W-1:0] idx;
		logic signed [VAL_W-1:0] vx;
		logic signed [VAL_W-1:0] vy;
		logic signed [VAL_W-1:0] px;
		logic signed [VAL_W-1:0] py;
	} gbk_pay_t;

	// Query payload while the grids are interpolated.
	typedef struct packed {
		logic oog;
		logic signed [VAL_W-1:0] px;
		logic signed [VAL_W-1:0] py;
	} gbk_res_t;

	// Request into one grid: an entry write or a cell read.
	typedef struct packed {
		logic rd;
		logic wr;
		logic [IDX_W-1:0] widx;
		logic signed [VAL_W-1:0] wval;
		logic [COL_W-1:0] ix;
		logic [ROW_W-1:0] iy;
		logic [FRAC_W-1:0] fx;
		logic [FRAC_W-1:0] fy;
	} gbk_req_t;

endpackage

@@ rtl/gbk_div.sv @@
module gbk_div (
	input logic clk,
	input logic en,
	input logic signed [gbk_pkg::REL_W-1:0] rel,
	input logic [gbk_pkg::SIZE_W-1:0] size,
	output logic [gbk_pkg::QUO_W-1:0] quo,
	output logic oor
);
	import gbk_pkg::*;

	localparam int NSTG = QUO_W / 2;

	// One restoring step: shift the remainder, subtract the divisor if it fits.
	function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] r,
		input logic [DIV_W-1:0] d);
		logic [DIV_W:0] t;
		t = {r, 1'b0};
		if (t >= {1'b0, d})
			return {1'b1, DIV_W'(t - {1'b0, d})};
		else
			return {1'b0, t[DIV_W-1:0]};
	endfunction

	logic [DIV_W-1:0] dd;
	logic [DIV_W-1:0] rem_s [NSTG+1];
	logic [QUO_W-1:0] quo_s [NSTG+1];
	logic oor_s [NSTG+1];

	// The divisor is the cell size times the grid width, so the quotient of
	// rel by it, taken to QUO_W fraction bits, is the index and weight at once.
	assign dd = {(size == '0) ? SIZE_W'(1) : size, COL_W'(0)};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DIV_W'(rel[REL_W-2:0]);
			quo_s[0] <= '0;
			oor_s[0] <= rel[REL_W-1] || (DIV_W'(rel[REL_W-2:0]) >= dd);
		end
	end

	for (genvar g = 1; g <= NSTG; g++) begin : g_stg
		logic [DIV_W:0] st_a;
		logic [DIV_W:0] st_b;
		assign st_a = div_step(rem_s[g-1], dd);
		assign st_b = div_step(st_a[DIV_W-1:0], dd);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= st_b[DIV_W-1:0];
				quo_s[g] <= {quo_s[g-1][QUO_W-3:0], st_a[DIV_W], st_b[DIV_W]};
				oor_s[g] <= oor_s[g-1];
			end
		end
	end

	assign quo = quo_s[NSTG];
	assign oor = oor_s[NSTG];

endmodule

@@ rtl/gbk_interp.sv @@
module gbk_interp (
	input logic clk,
	input logic en,
	input gbk_pkg::gbk_req_t req,
	output logic signed [gbk_pkg::VAL_W-1:0] field
);
	import gbk_pkg::*;

	localparam logic [FRAC_W:0] ONE = (FRAC_W+1)'(1 << FRAC_W);

	logic signed [VAL_W-1:0] rd_s1 [4];
	logic px_s1, py_s1;
	logic [FRAC_W-1:0] fx_s1, fy_s1, fy_s2, fy_s3;
	logic signed [VAL_W-1:0] v00, v10, v01, v11;
	logic [FRAC_W:0] wfx, wfy;
	logic signed [VAL_W+FRAC_W+1:0] p00_s2, p10_s2, p01_s2, p11_s2;
	logic signed [VAL_W+FRAC_W+2:0] r0_s3, r1_s3;
	logic signed [VAL_W+2*FRAC_W+4:0] t0_s4, t1_s4;
	logic signed [VAL_W+2*FRAC_W+5:0] tsum;
	logic signed [VAL_W-1:0] field_s5;

	// Four banks split by row and column parity, so the four corners of any
	// cell sit in different banks and are read in the same cycle.
	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic CB = (b % 2) == 1;
		localparam logic RB = (b / 2) == 1;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [BANK_AW-1:0] raddr, waddr;
		logic wsel;
		logic signed [VAL_W-1:0] mem [BANK_DEPTH];

		assign col = (req.ix[0] == CB) ? req.ix : req.ix + COL_W'(1);
		assign row = (req.iy[0] == RB) ? req.iy : req.iy + ROW_W'(1);
		assign raddr = {row[ROW_W-1:1], col[COL_W-1:1]};
		assign waddr = {req.widx[IDX_W-1:COL_W+1], req.widx[COL_W-1:1]};
		assign wsel = (req.widx[COL_W] == RB) && (req.widx[0] == CB);

		always_ff @(posedge clk) begin
			if (en && req.wr && wsel)
				mem[waddr] <= req.wval;
			if (en && req.rd)
				rd_s1[b] <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= req.ix[0];
			py_s1 <= req.iy[0];
			fx_s1 <= req.fx;
			fy_s1 <= req.fy;
		end
	end

	assign v00 = rd_s1[{py_s1, px_s1}];
	assign v10 = rd_s1[{py_s1, ~px_s1}];
	assign v01 = rd_s1[{~py_s1, px_s1}];
	assign v11 = rd_s1[{~py_s1, ~px_s1}];
	assign wfx = ONE - {1'b0, fx_s1};
	assign wfy = ONE - {1'b0, fy_s3};

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s2 <= v00 * $signed({1'b0, wfx});
			p10_s2 <= v10 * $signed({2'b0, fx_s1});
			p01_s2 <= v01 * $signed({1'b0, wfx});
			p11_s2 <= v11 * $signed({2'b0, fx_s1});
			fy_s2 <= fy_s1;
			r0_s3 <= {p00_s2[VAL_W+FRAC_W+1], p00_s2} + {p10_s2[VAL_W+FRAC_W+1], p10_s2};
			r1_s3 <= {p01_s2[VAL_W+FRAC_W+1], p01_s2} + {p11_s2[VAL_W+FRAC_W+1], p11_s2};
			fy_s3 <= fy_s2;
			t0_s4 <= r0_s3 * $signed({1'b0, wfy});
			t1_s4 <= r1_s3 * $signed({2'b0, fy_s3});
			field_s5 <= tsum[2*FRAC_W+VAL_W-1:2*FRAC_W];
		end
	end

	// Round half up to the output's sixteen fraction bits.
	assign tsum = {t0_s4[VAL_W+2*FRAC_W+4], t0_s4} + {t1_s4[VAL_W+2*FRAC_W+4], t1_s4}
		+ (VAL_W+2*FRAC_W+6)'(64'sh8000_0000);

	assign field = field_s5;

endmodule

@@ rtl/grid_bilinear_field_kick.sv @@
// Bilinear field kick: two 64 by 64 grids of Q16.16 field values are loaded
// one entry per write transaction (tuser 0), and each query transaction
// (tuser 1) returns the particle position kicked by kick_factor times the
// bilinear interpolation of both grids, saturated to 32 bits, or the position
// unchanged with out_of_grid set when its cell falls outside the columns and
// rows in use. One transaction is taken in every cycle that the output side
// does not stall. A query passes 21 register stages, most of them in the
// pipelined divider that finds each cell index and weight two quotient bits
// a stage, followed by the registered grid read from four parity banks and
// the multiply stages. Writes return nothing and take effect in order with
// respect to queries. The user must write configuration through the plain
// write port only while no transaction is in flight; the block itself does
// not enforce this.
`include "grid_bilinear_field_kick_macros.svh"

module grid_bilinear_field_kick (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [gbk_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [gbk_pkg::CFG_W-1:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	// [11:0] entry_index, [43:12] entry_value_x, [75:44] entry_value_y,
	// [107:76] pos_x, [139:108] pos_y, [143:140] zero
	input logic [gbk_pkg::S_TDATA_W-1:0] s_tdata,
	// [0] cmd
	input logic [0:0] s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// [31:0] new_x, [63:32] new_y
	output logic [gbk_pkg::M_TDATA_W-1:0] m_tdata,
	// [0] out_of_grid
	output logic [0:0] m_tuser
);
	import gbk_pkg::*;

	// Clamp a 49-bit sum into the signed 32-bit range.
	function automatic logic [VAL_W-1:0] sat32(input logic signed [VAL_W+16:0] v);
		if (v[VAL_W+16:VAL_W-1] == {18{v[VAL_W-1]}})
			return v[VAL_W-1:0];
		else if (v[VAL_W+16])
			return {1'b1, {(VAL_W-1){1'b0}}};
		else
			return {1'b0, {(VAL_W-1){1'b1}}};
	endfunction

	// Configuration registers.
	logic signed [VAL_W-1:0] origin_x_q, origin_y_q, kick_q;
	logic [SIZE_W-1:0] cell_dx_q, cell_dy_q;
	logic [CNT_W-1:0] cols_q, rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			cell_dx_q <= SIZE_W'(65536);
			cell_dy_q <= SIZE_W'(65536);
			cols_q <= CNT_W'(64);
			rows_q <= CNT_W'(64);
			kick_q <= VAL_W'(655360);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_X: origin_x_q <= cfg_data;
				REG_ORIGIN_Y: origin_y_q <= cfg_data;
				REG_CELL_DX: cell_dx_q <= cfg_data[SIZE_W-1:0];
				REG_CELL_DY: cell_dy_q <= cfg_data[SIZE_W-1:0];
				REG_COLS: cols_q <= cfg_data[CNT_W-1:0];
				REG_ROWS: rows_q <= cfg_data[CNT_W-1:0];
				REG_KICK: kick_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The whole pipeline moves together; the output register frees its slot
	// in the same cycle that its result is taken.
	logic adv;
	logic vld_s21;
	assign adv = !vld_s21 || m_tready;
	assign s_tready = adv;

	// Stage 1: unpack the transaction and form the offset from the origin.
	gbk_pay_t pay_in, pay_s1;
	logic vld_s1;
	logic signed [REL_W-1:0] rel_x_s1, rel_y_s1;

	assign pay_in.cmd = s_tuser[0];
	assign pay_in.idx = s_tdata[11:0];
	assign pay_in.vx = s_tdata[43:12];
	assign pay_in.vy = s_tdata[75:44];
	assign pay_in.px = s_tdata[107:76];
	assign pay_in.py = s_tdata[139:108];

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_s1 <= pay_in;
			rel_x_s1 <= {pay_in.px[VAL_W-1], pay_in.px} - {origin_x_q[VAL_W-1], origin_x_q};
			rel_y_s1 <= {pay_in.py[VAL_W-1], pay_in.py} - {origin_y_q[VAL_W-1], origin_y_q};
		end
	end

	// Stages 2 to 13: the dividers turn each offset into a cell index in the
	// upper quotient bits and a Q16 weight in the lower ones, and flag a
	// negative offset or one beyond the full grid.
	logic [QUO_W-1:0] quo_x, quo_y;
	logic oor_x, oor_y;

	gbk_div u_div_x (
		.clk(clk), .en(adv), .rel(rel_x_s1), .size(cell_dx_q), .quo(quo_x), .oor(oor_x)
	);
	gbk_div u_div_y (
		.clk(clk), .en(adv), .rel(rel_y_s1), .size(cell_dy_q), .quo(quo_y), .oor(oor_y)
	);

	logic vld_d_s [DIV_LAT];
	gbk_pay_t pay_d_s [DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++)
				vld_d_s[i] <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_d_s[0] <= vld_s1;
			for (int i = 1; i < DIV_LAT; i++)
				vld_d_s[i] <= vld_d_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_d_s[0] <= pay_s1;
			for (int i = 1; i < DIV_LAT; i++)
				pay_d_s[i] <= pay_d_s[i-1];
		end
	end

	// Cell check against the columns and rows in use, held to the grid size.
	gbk_pay_t pn;
	logic vn, oog_n;
	logic [COL_W-1:0] ix_n;
	logic [ROW_W-1:0] iy_n;
	logic [CNT_W-1:0] ix_n1, iy_n1, cols_eff, rows_eff;

	assign pn = pay_d_s[DIV_LAT-1];
	assign vn = vld_d_s[DIV_LAT-1];
	assign ix_n = quo_x[QUO_W-1:FRAC_W];
	assign iy_n = quo_y[QUO_W-1:FRAC_W];
	assign ix_n1 = CNT_W'(ix_n) + CNT_W'(1);
	assign iy_n1 = CNT_W'(iy_n) + CNT_W'(1);
	assign cols_eff = (cols_q > CNT_W'(GRID_COLS)) ? CNT_W'(GRID_COLS) : cols_q;
	assign rows_eff = (rows_q > CNT_W'(GRID_ROWS)) ? CNT_W'(GRID_ROWS) : rows_q;
	assign oog_n = oor_x || oor_y || (ix_n1 >= cols_eff) || (iy_n1 >= rows_eff);

	// Stages 14 to 18: grid writes land here too, in transaction order, so a
	// query never sees a write that followed it.
	gbk_req_t req_x, req_y;
	logic signed [VAL_W-1:0] field_x, field_y;

	assign req_x.rd = vn && (pn.cmd == CMD_QUERY);
	assign req_x.wr = vn && (pn.cmd == CMD_WRITE);
	assign req_x.widx = pn.idx;
	assign req_x.wval = pn.vx;
	assign req_x.ix = ix_n;
	assign req_x.iy = iy_n;
	assign req_x.fx = quo_x[FRAC_W-1:0];
	assign req_x.fy = quo_y[FRAC_W-1:0];

	always_comb begin
		req_y = req_x;
		req_y.wval = pn.vy;
	end

	gbk_interp u_interp_x (.clk(clk), .en(adv), .req(req_x), .field(field_x));
	gbk_interp u_interp_y (.clk(clk), .en(adv), .req(req_y), .field(field_y));

	logic res_i_s [INT_LAT];
	gbk_res_t rdat_i_s [INT_LAT];
	gbk_res_t rdat_n;

	assign rdat_n.oog = oog_n;
	assign rdat_n.px = pn.px;
	assign rdat_n.py = pn.py;

	always_ff @(posedge clk) begin
		if (adv) begin
			rdat_i_s[0] <= rdat_n;
			for (int i = 1; i < INT_LAT; i++)
				rdat_i_s[i] <= rdat_i_s[i-1];
		end
	end

	// Stages 19 to 21: scale, round, add to the position and saturate.
	logic vld_s19, vld_s20;
	gbk_res_t rdat_s19, rdat_s20;
	logic signed [2*VAL_W-1:0] prod_x_s19, prod_y_s19, rnd_x, rnd_y;
	logic signed [VAL_W+15:0] kick_x_s20, kick_y_s20;
	logic [VAL_W-1:0] new_x_s21, new_y_s21;
	logic oog_s21;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < INT_LAT; i++)
				res_i_s[i] <= 1'b0;
			vld_s19 <= 1'b0;
			vld_s20 <= 1'b0;
			vld_s21 <= 1'b0;
		end else if (adv) begin
			res_i_s[0] <= req_x.rd;
			for (int i = 1; i < INT_LAT; i++)
				res_i_s[i] <= res_i_s[i-1];
			vld_s19 <= res_i_s[INT_LAT-1];
			vld_s20 <= vld_s19;
			vld_s21 <= vld_s20;
		end
	end

	assign rnd_x = prod_x_s19 + 64'sh8000;
	assign rnd_y = prod_y_s19 + 64'sh8000;

	always_ff @(posedge clk) begin
		if (adv) begin
			rdat_s19 <= rdat_i_s[INT_LAT-1];
			prod_x_s19 <= kick_q * field_x;
			prod_y_s19 <= kick_q * field_y;
			rdat_s20 <= rdat_s19;
			kick_x_s20 <= rnd_x[2*VAL_W-1:FRAC_W];
			kick_y_s20 <= rnd_y[2*VAL_W-1:FRAC_W];
			oog_s21 <= rdat_s20.oog;
			if (rdat_s20.oog) begin
				new_x_s21 <= rdat_s20.px;
				new_y_s21 <= rdat_s20.py;
			end else begin
				new_x_s21 <= sat32((VAL_W+17)'(rdat_s20.px) + (VAL_W+17)'(kick_x_s20));
				new_y_s21 <= sat32((VAL_W+17)'(rdat_s20.py) + (VAL_W+17)'(kick_y_s20));
			end
		end
	end

	assign m_tvalid = vld_s21;
	assign m_tdata = {new_y_s21, new_x_s21};
	assign m_tuser = oog_s21;

	// A stalled product stage keeps its position and flag until the pipeline moves.
	`GBK_ASSERT_NEXT(a_stall_hold, vld_s19 && !adv, vld_s19 && $stable(rdat_s19), "stall lost data")
	// A grid write never turns into a result.
	`GBK_ASSERT_NEXT(a_write_silent, adv && vn && (pn.cmd == CMD_WRITE), !res_i_s[0], "write made a result")
	// A cell that passes the check has its right and next-row neighbors inside the grid.
	`GBK_ASSERT_NOW(a_cell_bound, req_x.rd && !oog_n, ix_n1 < CNT_W'(GRID_COLS) && iy_n1 < CNT_W'(GRID_ROWS), "cell beyond grid")

endmodule
